/* sv/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and defaults shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // default sizing
  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned ALIGN_BYTES_DEF  = 8;

  localparam logic [31:0] HEAP_LIMIT_RST = 32'd1048576;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NO_HEAP  = 3'd2;
  localparam logic [2:0] ST_TBL_FULL = 3'd3;
  localparam logic [2:0] ST_BAD_FREE = 3'd4;

  // input transaction
  typedef struct packed {
    logic        kind;
    logic [31:0] request_size;
    logic [31:0] payload_address;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
  } rsp_t;

  // one block table entry
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        used;
  } entry_t;

  // datapath operations
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV,
    CMD_ROUND,
    CMD_SCAN_RD,
    CMD_SCAN_NEXT,
    CMD_TAKE,
    CMD_SW_RD,
    CMD_SW_WR,
    CMD_SPLIT,
    CMD_WR_CUR,
    CMD_GROW,
    CMD_NXT_RD,
    CMD_MERGE_N,
    CMD_MERGE_P,
    CMD_DROP_END,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [2:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic addr_zero;
    logic div_done;
    logic scan_end;
    logic hit;
    logic hit_used;
    logic can_split;
    logic grow_ovf;
    logic tbl_full;
    logic has_next;
    logic next_merge;
    logic prev_merge;
    logic sweep_done;
  } dp_sts_t;

endpackage

/* sv/ffha_ram.sv */
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ffha_dp.sv */
// ----------------------------------------------------------------------------
// ffha_dp
// Allocator datapath: block table RAM, size rounding, scan, shift and merge
// arithmetic, heap end and limit registers, result register.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  req_t        req_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic        done_o,
  output rsp_t        rsp_o
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned RW = $clog2(ALIGN_BYTES) + 1;
  localparam logic [33:0] HDR = 34'(HEADER_BYTES);
  localparam logic [33:0] ALN = 34'(ALIGN_BYTES);

  // remainder by the alignment: fold the upper half in by 2^16 mod align,
  // then divide the 22-bit sum by reciprocal multiply
  localparam int unsigned SH    = 22 + $clog2(ALIGN_BYTES);
  localparam logic [21:0] FOLD  = 22'(32'd65536 % ALIGN_BYTES);
  localparam logic [21:0] ALN_W = 22'(ALIGN_BYTES);
  localparam logic [23:0] RCP   =
    24'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

  // request capture and rounding
  logic          kind_q;
  logic [31:0]   req_q, addr_q;
  logic [RW-1:0] rem_q;
  logic [1:0]    step_q;
  logic [21:0]   fold_q, quo_q;
  logic [32:0]   sz_q;

  // table bookkeeping
  logic [CW-1:0] idx_q, count_q, k_q, stop_q;
  logic          up_q;
  logic [31:0]   heap_end_q, limit_q, res_addr_q;
  entry_t        cur_q, prv_q;
  logic [IW-1:0] cur_idx_q;

  logic          done_q;
  rsp_t          rsp_q;

  // RAM port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rd;

  ffha_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // shared arithmetic
  logic [45:0]   quo_prod;
  logic [33:0]   new_end, rd_end, cur_end, prv_end;
  logic [CW-1:0] k_m1, k_p1, cur_idx_w;

  assign quo_prod  = 46'(fold_q) * 46'(RCP);
  assign new_end   = 34'(heap_end_q) + HDR + 34'(sz_q);
  assign rd_end    = 34'(rd.start) + HDR;
  assign cur_end   = 34'(cur_q.start) + HDR + 34'(cur_q.size);
  assign prv_end   = 34'(prv_q.start) + HDR + 34'(prv_q.size);
  assign k_m1      = k_q - CW'(1);
  assign k_p1      = k_q + CW'(1);
  assign cur_idx_w = CW'(cur_idx_q);

  // status toward controller
  always_comb begin
    sts_o.is_free    = kind_q;
    sts_o.req_zero   = (req_q == 32'd0);
    sts_o.addr_zero  = (addr_q == 32'd0);
    sts_o.div_done   = (step_q == 2'd2);
    sts_o.scan_end   = (idx_q == count_q);
    sts_o.hit        = kind_q ? (rd_end == 34'(addr_q))
                              : (!rd.used && (33'(rd.size) >= sz_q));
    sts_o.hit_used   = rd.used;
    sts_o.can_split  = (34'(rd.size) >= 34'(sz_q) + HDR + ALN) &&
                       (count_q < CW'(MAX_BLOCKS));
    sts_o.grow_ovf   = (new_end > 34'(limit_q));
    sts_o.tbl_full   = (count_q == CW'(MAX_BLOCKS));
    sts_o.has_next   = (cur_idx_w + CW'(1) < count_q);
    sts_o.next_merge = !rd.used && (cur_end == 34'(rd.start));
    sts_o.prev_merge = (cur_idx_q != '0) && !prv_q.used &&
                       (prv_end == 34'(cur_q.start));
    sts_o.sweep_done = (k_q == stop_q);
  end

  // RAM address and write selection
  always_comb begin
    we    = 1'b0;
    waddr = cur_idx_q;
    wdata = cur_q;
    raddr = idx_q[IW-1:0];
    case (cmd_i.op)
      CMD_SW_RD:  raddr = up_q ? k_m1[IW-1:0] : k_p1[IW-1:0];
      CMD_NXT_RD: raddr = cur_idx_q + IW'(1);
      CMD_SW_WR: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rd;
      end
      CMD_SPLIT: begin
        we          = 1'b1;
        waddr       = cur_idx_q + IW'(1);
        wdata.start = 32'(34'(cur_q.start) + HDR + 34'(sz_q));
        wdata.size  = 32'(34'(cur_q.size) - 34'(sz_q) - HDR);
        wdata.used  = 1'b0;
      end
      CMD_WR_CUR: we = 1'b1;
      CMD_GROW: begin
        we          = 1'b1;
        waddr       = count_q[IW-1:0];
        wdata.start = heap_end_q;
        wdata.size  = sz_q[31:0];
        wdata.used  = 1'b1;
      end
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        kind_q <= req_i.kind;
        req_q  <= req_i.request_size;
        addr_q <= req_i.payload_address;
        step_q <= '0;
      end
      // fold, reciprocal quotient, remainder: one step per cycle
      CMD_DIV: begin
        case (step_q)
          2'd0:    fold_q <= 22'(req_q[31:16]) * FOLD + 22'(req_q[15:0]);
          2'd1:    quo_q  <= 22'(quo_prod >> SH);
          default: rem_q  <= RW'(fold_q - quo_q * ALN_W);
        endcase
        step_q <= step_q + 2'd1;
      end
      CMD_ROUND:
        sz_q <= 33'(req_q) + ((rem_q == '0) ? 33'd0 : 33'(ALIGN_BYTES) - 33'(rem_q));
      CMD_SCAN_NEXT: prv_q <= rd;
      CMD_TAKE: begin
        cur_q      <= rd;
        cur_q.used <= !kind_q;
        cur_idx_q  <= idx_q[IW-1:0];
        res_addr_q <= 32'(rd_end);
        k_q        <= count_q;
        stop_q     <= idx_q + CW'(1);
        up_q       <= 1'b1;
      end
      CMD_SW_WR: k_q <= up_q ? k_m1 : k_p1;
      CMD_SPLIT: cur_q.size <= sz_q[31:0];
      CMD_MERGE_N: begin
        cur_q.size <= 32'(34'(cur_q.size) + HDR + 34'(rd.size));
        k_q        <= cur_idx_w + CW'(1);
        stop_q     <= count_q - CW'(1);
        up_q       <= 1'b0;
      end
      CMD_MERGE_P: begin
        cur_q.start <= prv_q.start;
        cur_q.size  <= 32'(34'(prv_q.size) + HDR + 34'(cur_q.size));
        cur_q.used  <= 1'b0;
        cur_idx_q   <= cur_idx_q - IW'(1);
        k_q         <= cur_idx_w;
        stop_q      <= count_q - CW'(1);
        up_q        <= 1'b0;
      end
      CMD_GROW: res_addr_q <= 32'(34'(heap_end_q) + HDR);
      CMD_FIN: begin
        rsp_q.status         <= cmd_i.status;
        rsp_q.result_address <= (cmd_i.status == ST_OK && kind_q == KIND_ALLOC) ?
                                res_addr_q : 32'd0;
      end
      default: ;
    endcase
  end

  // control registers: table fill, heap end, limit, scan index, strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      heap_end_q <= '0;
      limit_q    <= HEAP_LIMIT_RST;
      idx_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == CMD_FIN);
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        CMD_LOAD:      idx_q   <= '0;
        CMD_SCAN_NEXT: idx_q   <= idx_q + CW'(1);
        CMD_SPLIT:     count_q <= count_q + CW'(1);
        CMD_DROP_END:  count_q <= count_q - CW'(1);
        CMD_GROW: begin
          count_q    <= count_q + CW'(1);
          heap_end_q <= new_end[31:0];
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* sv/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// Allocator controller: sequences rounding, scan, split, grow and merge
// steps on the datapath.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_PREP     = 20'h00002,
    S_DIV      = 20'h00004,
    S_ROUND    = 20'h00008,
    S_SCAN_RD  = 20'h00010,
    S_SCAN_CHK = 20'h00020,
    S_UP_RD    = 20'h00040,
    S_UP_WR    = 20'h00080,
    S_SPLIT    = 20'h00100,
    S_WR_CUR   = 20'h00200,
    S_GROW     = 20'h00400,
    S_NXT_RD   = 20'h00800,
    S_NXT_CHK  = 20'h01000,
    S_DN1_RD   = 20'h02000,
    S_DN1_WR   = 20'h04000,
    S_PRV_CHK  = 20'h08000,
    S_WR_P     = 20'h10000,
    S_DN2_RD   = 20'h20000,
    S_DN2_WR   = 20'h40000,
    S_FIN      = 20'h80000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] code_q, code_d;

  // next state and command
  always_comb begin
    state_d       = state_q;
    code_d        = code_q;
    cmd_o.op      = CMD_NONE;
    cmd_o.status  = code_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        if (sts_i.is_free ? sts_i.addr_zero : sts_i.req_zero) begin
          code_d  = ST_ZERO;
          state_d = S_FIN;
        end else begin
          state_d = sts_i.is_free ? S_SCAN_RD : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = CMD_DIV;
        if (sts_i.div_done) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.op = CMD_ROUND;
        state_d  = S_SCAN_RD;
      end
      // first-fit / lookup scan: read an entry, then check it
      S_SCAN_RD: begin
        if (sts_i.scan_end) begin
          if (sts_i.is_free) begin
            code_d  = ST_BAD_FREE;
            state_d = S_FIN;
          end else begin
            state_d = S_GROW;
          end
        end else begin
          cmd_o.op = CMD_SCAN_RD;
          state_d  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!sts_i.hit) begin
          cmd_o.op = CMD_SCAN_NEXT;
          state_d  = S_SCAN_RD;
        end else if (sts_i.is_free) begin
          if (sts_i.hit_used) begin
            cmd_o.op = CMD_TAKE;
            state_d  = S_NXT_RD;
          end else begin
            code_d  = ST_BAD_FREE;
            state_d = S_FIN;
          end
        end else begin
          cmd_o.op = CMD_TAKE;
          state_d  = sts_i.can_split ? S_UP_RD : S_WR_CUR;
        end
      end
      // open a slot after the taken block
      S_UP_RD: begin
        if (sts_i.sweep_done) begin
          state_d = S_SPLIT;
        end else begin
          cmd_o.op = CMD_SW_RD;
          state_d  = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd_o.op = CMD_SW_WR;
        state_d  = S_UP_RD;
      end
      S_SPLIT: begin
        cmd_o.op = CMD_SPLIT;
        state_d  = S_WR_CUR;
      end
      S_WR_CUR: begin
        cmd_o.op = CMD_WR_CUR;
        code_d   = ST_OK;
        state_d  = S_FIN;
      end
      // append at heap end
      S_GROW: begin
        if (sts_i.grow_ovf) begin
          code_d = ST_NO_HEAP;
        end else if (sts_i.tbl_full) begin
          code_d = ST_TBL_FULL;
        end else begin
          cmd_o.op = CMD_GROW;
          code_d   = ST_OK;
        end
        state_d = S_FIN;
      end
      // merge with next neighbor
      S_NXT_RD: begin
        if (sts_i.has_next) begin
          cmd_o.op = CMD_NXT_RD;
          state_d  = S_NXT_CHK;
        end else begin
          state_d = S_PRV_CHK;
        end
      end
      S_NXT_CHK: begin
        if (sts_i.next_merge) begin
          cmd_o.op = CMD_MERGE_N;
          state_d  = S_DN1_RD;
        end else begin
          state_d = S_PRV_CHK;
        end
      end
      S_DN1_RD: begin
        if (sts_i.sweep_done) begin
          cmd_o.op = CMD_DROP_END;
          state_d  = S_PRV_CHK;
        end else begin
          cmd_o.op = CMD_SW_RD;
          state_d  = S_DN1_WR;
        end
      end
      S_DN1_WR: begin
        cmd_o.op = CMD_SW_WR;
        state_d  = S_DN1_RD;
      end
      // merge with previous neighbor
      S_PRV_CHK: begin
        if (sts_i.prev_merge) begin
          cmd_o.op = CMD_MERGE_P;
          state_d  = S_WR_P;
        end else begin
          cmd_o.op = CMD_WR_CUR;
          code_d   = ST_OK;
          state_d  = S_FIN;
        end
      end
      S_WR_P: begin
        cmd_o.op = CMD_WR_CUR;
        state_d  = S_DN2_RD;
      end
      S_DN2_RD: begin
        if (sts_i.sweep_done) begin
          cmd_o.op = CMD_DROP_END;
          code_d   = ST_OK;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = CMD_SW_RD;
          state_d  = S_DN2_WR;
        end
      end
      S_DN2_WR: begin
        cmd_o.op = CMD_SW_WR;
        state_d  = S_DN2_RD;
      end
      S_FIN: begin
        cmd_o.op = CMD_FIN;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* sv/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block split on allocate and neighbor
// coalescing on free, over an address-ordered block table in RAM.
// ----------------------------------------------------------------------------
//  Channel   Ports                        Transaction
//  request   start, busy, req_i           accepted when start & !busy
//  result    done_o, rsp_o                one cycle, marked by done_o
//  config    cfg_we_i, cfg_wdata_i        heap_limit, written when cfg_we_i
//
//  One request at a time. An allocate first does the zero check and size
//  rounding (a three-step constant remainder), then reads and checks each
//  table entry scanned, and reads and writes each entry moved when a split
//  opens a slot. A free reads and checks each entry scanned, plus reads and
//  writes each entry moved for each merge. The table RAM's single read and
//  write port sets the per-entry cost. done_o pulses the cycle after the
//  request finishes. Reset needs no clearing pass; results cannot be stalled.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ffha_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule
